// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/qrpp_pkg.sv =====
// Types and constants for the query response packet parser.
// No dependencies.
`default_nettype none
package qrpp_pkg;
  localparam logic [7:0] TypeChallenge = 8'h41;
  localparam logic [7:0] TypeInfo      = 8'h49;
  localparam logic [7:0] TypeRules     = 8'h45;
  localparam logic [7:0] TypePlayers   = 8'h44;

  localparam logic [0:0] RegWantRules   = 1'b0;
  localparam logic [0:0] RegWantPlayers = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR, PH_SKIP, PH_CHAL, PH_CHAL_DONE, PH_PROTO,
    PH_S0, PH_S1, PH_S2, PH_S3, PH_FIXED, PH_VERSION, PH_INFO_DONE,
    PH_RCOUNT, PH_KEY, PH_VALUE, PH_REC_END, PH_TRAIL,
    PH_PCOUNT, PH_PIDX, PH_PNAME, PH_FRAGS, PH_PTIME
  } phase_e;

  typedef enum logic [4:0] {
    FK_STATUS = 5'd0, FK_CHAL = 5'd1, FK_PROTO = 5'd2, FK_STR0 = 5'd3,
    FK_PLAYERS = 5'd7, FK_SLOTS = 5'd8, FK_DEDI = 5'd9, FK_OS = 5'd10,
    FK_PASS = 5'd11, FK_SECURE = 5'd12, FK_VERSION = 5'd13, FK_KEY = 5'd14,
    FK_VALUE = 5'd15, FK_PIDX = 5'd16, FK_PNAME = 5'd17, FK_FRAGS = 5'd18,
    FK_TIME = 5'd19
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SHORT = 2'd1, ST_BAD_HDR = 2'd2, ST_BAD_TYPE = 2'd3
  } status_e;

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic        str_end;
    logic [15:0] rec;
    logic [1:0]  status;
    logic        cnt_short;
    logic        trail;
    logic        complete;
    logic        last;
  } item_t;

  // Up to two items caused by one byte.
  typedef struct packed {
    logic  v0;
    logic  v1;
    item_t i0;
    item_t i1;
  } pair_t;
endpackage
`default_nettype wire

// ===== design/qrpp_front.sv =====
// Front end: builds result items, stepping the parse state one byte per cycle while step_i is high.
// Depends on qrpp_pkg.
`default_nettype none
module qrpp_front import qrpp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic  final_byte_i,
  input  wire logic  want_rules_i,
  input  wire logic  want_players_i,
  output pair_t      pair_o
);
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d, left_q, left_d, idx_q, idx_d;
  logic [2:0]  pkind_q, pkind_d;
  logic [3:0]  sub_q, sub_d, flags_q, flags_d, fl;
  logic [31:0] ws_q, ws_d, ws_sh;
  logic [1:0]  err_q, err_d, st;
  logic        emit, rec_str, is_ok;
  item_t       fi, si;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; pos_q <= '0; left_q <= '0; idx_q <= '0;
      pkind_q <= '0; sub_q <= '0; flags_q <= '0; ws_q <= '0; err_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; pos_q <= pos_d; left_q <= left_d; idx_q <= idx_d;
      pkind_q <= pkind_d; sub_q <= sub_d; flags_q <= flags_d; ws_q <= ws_d;
      err_q <= err_d;
    end
  end

  always_comb begin
    phase_d = phase_q; left_d = left_q; idx_d = idx_q; pkind_d = pkind_q;
    sub_d = sub_q; ws_d = ws_q; err_d = err_q; flags_d = flags_q;
    ws_sh = {rx_byte_i, ws_q[31:8]};
    emit = 1'b0;
    fi = '0;
    fi.value = {24'd0, rx_byte_i};
    case (phase_q)
      PH_HDR: begin
        if (pos_q < 16'd4) begin
          if (rx_byte_i != 8'hFF) begin err_d = ST_BAD_HDR; phase_d = PH_SKIP; end
        end else begin
          sub_d = '0; ws_d = '0;
          if (rx_byte_i == TypeChallenge) begin pkind_d = 3'd1; phase_d = PH_CHAL; end
          else if (rx_byte_i == TypeInfo) begin pkind_d = 3'd2; phase_d = PH_PROTO; end
          else if (rx_byte_i == TypeRules) begin pkind_d = 3'd3; phase_d = PH_RCOUNT; end
          else if (rx_byte_i == TypePlayers) begin
            pkind_d = 3'd4; phase_d = PH_PCOUNT;
          end else begin err_d = ST_BAD_TYPE; phase_d = PH_SKIP; end
        end
      end
      PH_CHAL: begin
        ws_d = ws_sh;
        if (sub_q >= 4'd3) begin
          emit = 1'b1; fi.kind = FK_CHAL; fi.value = ws_sh; phase_d = PH_CHAL_DONE;
        end else sub_d = sub_q + 4'd1;
      end
      PH_PROTO: begin emit = 1'b1; fi.kind = FK_PROTO; phase_d = PH_S0; end
      PH_S0, PH_S1, PH_S2, PH_S3: begin
        emit = 1'b1;
        fi.kind = FK_STR0 + (5'(phase_q) - 5'(PH_S0));
        fi.str_end = (rx_byte_i == 8'd0);
        if (rx_byte_i == 8'd0) begin
          phase_d = (phase_q == PH_S3) ? PH_FIXED : phase_e'(5'(phase_q) + 5'd1);
          sub_d = '0;
        end
      end
      PH_FIXED: begin
        case (sub_q)
          4'd2: begin emit = 1'b1; fi.kind = FK_PLAYERS; end
          4'd3: begin emit = 1'b1; fi.kind = FK_SLOTS; end
          4'd5: begin
            emit = 1'b1; fi.kind = FK_DEDI; fi.value = {31'd0, rx_byte_i != 8'd0};
          end
          4'd6: begin emit = 1'b1; fi.kind = FK_OS; end
          4'd7: begin emit = (rx_byte_i != 8'd0); fi.kind = FK_PASS; end
          4'd8: begin emit = (rx_byte_i != 8'd0); fi.kind = FK_SECURE; end
          default: ;
        endcase
        if (sub_q >= 4'd8) phase_d = PH_VERSION;
        else sub_d = sub_q + 4'd1;
      end
      PH_VERSION: begin
        emit = 1'b1; fi.kind = FK_VERSION; fi.str_end = (rx_byte_i == 8'd0);
        if (rx_byte_i == 8'd0) phase_d = PH_INFO_DONE;
      end
      PH_RCOUNT: begin
        if (sub_q == 4'd0) begin left_d = {8'd0, rx_byte_i}; sub_d = 4'd1; end
        else begin
          left_d = {rx_byte_i, left_q[7:0]};
          sub_d = '0;
          phase_d = (left_d != 16'd0) ? PH_KEY : PH_REC_END;
        end
      end
      PH_KEY, PH_VALUE: begin
        emit = 1'b1;
        fi.kind = (phase_q == PH_KEY) ? FK_KEY : FK_VALUE;
        fi.str_end = (rx_byte_i == 8'd0); fi.rec = idx_q;
        if (rx_byte_i != 8'd0) sub_d = 4'd1;
        else begin
          sub_d = '0;
          if (phase_q == PH_KEY) phase_d = PH_VALUE;
          else begin
            left_d = left_q - 16'd1; idx_d = idx_q + 16'd1;
            phase_d = (left_d != 16'd0) ? PH_KEY : PH_REC_END;
          end
        end
      end
      PH_REC_END, PH_TRAIL: phase_d = PH_TRAIL;
      PH_PCOUNT: begin
        left_d = {8'd0, rx_byte_i};
        phase_d = (rx_byte_i != 8'd0) ? PH_PIDX : PH_REC_END;
      end
      PH_PIDX: begin
        emit = 1'b1; fi.kind = FK_PIDX; fi.rec = idx_q; sub_d = '0; phase_d = PH_PNAME;
      end
      PH_PNAME: begin
        emit = 1'b1; fi.kind = FK_PNAME; fi.rec = idx_q;
        fi.str_end = (rx_byte_i == 8'd0);
        if (rx_byte_i != 8'd0) sub_d = 4'd1;
        else begin sub_d = '0; ws_d = '0; phase_d = PH_FRAGS; end
      end
      PH_FRAGS, PH_PTIME: begin
        ws_d = ws_sh;
        if (sub_q >= 4'd3) begin
          emit = 1'b1; fi.kind = (phase_q == PH_FRAGS) ? FK_FRAGS : FK_TIME;
          fi.value = ws_sh; fi.rec = idx_q; sub_d = '0; ws_d = '0;
          if (phase_q == PH_FRAGS) phase_d = PH_PTIME;
          else begin
            left_d = left_q - 16'd1; idx_d = idx_q + 16'd1;
            phase_d = (left_d != 16'd0) ? PH_PIDX : PH_REC_END;
          end
        end else sub_d = sub_q + 4'd1;
      end
      default: ;
    endcase

    pos_d = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;

    // End-of-datagram status, from the state after this byte.
    rec_str = (phase_d == PH_KEY) || (phase_d == PH_VALUE) || (phase_d == PH_PNAME);
    if (pos_d < 16'd5) st = ST_SHORT;
    else if (err_d != 2'd0) st = err_d;
    else if (phase_d == PH_CHAL_DONE || phase_d == PH_INFO_DONE || rec_str ||
             phase_d == PH_PIDX || phase_d == PH_REC_END || phase_d == PH_TRAIL)
      st = ST_OK;
    else st = ST_SHORT;
    is_ok = (st == ST_OK);
    fl = flags_q;
    if (is_ok) begin
      if (phase_d == PH_CHAL_DONE) fl[0] = 1'b1;
      else if (phase_d == PH_INFO_DONE) fl[1] = 1'b1;
      else if (pkind_d == 3'd3) fl[2] = 1'b1;
      else if (pkind_d == 3'd4) fl[3] = 1'b1;
    end
    si = '0;
    si.kind = FK_STATUS;
    si.value = {16'd0, pos_d};
    si.rec = idx_d;
    si.status = st;
    si.cnt_short = is_ok && (rec_str || phase_d == PH_PIDX);
    si.trail = is_ok && (phase_d == PH_TRAIL || (rec_str && sub_d != 4'd0));
    si.complete = (!want_players_i || fl[3]) && (!want_rules_i || fl[2]);
    si.last = 1'b1;
    fi.last = !final_byte_i;

    pair_o = '0;
    if (final_byte_i) begin
      flags_d = fl;
      phase_d = PH_HDR; pos_d = '0; pkind_d = '0; left_d = '0; idx_d = '0;
      sub_d = '0; ws_d = '0; err_d = '0;
    end
    // Status goes in the first slot when no field item precedes it.
    if (emit) begin
      pair_o.v0 = 1'b1; pair_o.i0 = fi;
      pair_o.v1 = final_byte_i; pair_o.i1 = si;
    end else begin
      pair_o.v0 = final_byte_i; pair_o.i0 = si;
    end
  end
endmodule
`default_nettype wire

// ===== design/qrpp_queue.sv =====
// Short queue of item pairs between the front end and the output stage.
// Depends on qrpp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module qrpp_queue import qrpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  pair_t     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output pair_t     data_o
);
  pair_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  `ASSERT_IMPL(a_no_overflow, push_i, !full_o, "queue push while full")
  `ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "queue pop while empty")
  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q != 2'd3, "queue count out of range")
endmodule
`default_nettype wire

// ===== design/qrpp_back.sv =====
// Back end: plays out one or two items per queued pair into an output register.
// Depends on qrpp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module qrpp_back import qrpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  pair_t     data_i,
  output logic      pop_o,
  input  wire logic stall_i,
  output logic      valid_o,
  output item_t     item_o
);
  logic  valid_q, sel_q, load;
  item_t item_q;

  // Output register free when empty or being taken this cycle.
  assign load  = !valid_q || !stall_i;
  assign pop_o = load && !empty_i && (sel_q || !data_i.v1 || !data_i.v0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; sel_q <= 1'b0;
    end else if (load) begin
      if (!empty_i && data_i.v0) begin
        valid_q <= 1'b1;
        sel_q <= data_i.v1 && !sel_q;
      end else begin
        valid_q <= 1'b0; sel_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) item_q <= sel_q ? data_i.i1 : data_i.i0;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  `ASSERT_IMPL(a_sel_has_second, sel_q, !empty_i && data_i.v1, "second slot missing")
  `ASSERT_NEXT(a_hold, valid_q && stall_i, valid_q && $stable(item_q), "output dropped")
  `ASSERT_IMPL(a_status_last, valid_q && item_q.kind == FK_STATUS, item_q.last,
    "status item not last")
endmodule
`default_nettype wire

// ===== design/query_response_packet_parser.sv =====
// Top level of the query response packet parser: APB registers, front, queue, back.
// Depends on qrpp_pkg, qrpp_front, qrpp_queue, qrpp_back.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o | rx_byte_i, final_byte_i
//  out     | output    | out_valid_o/out_stall_i | field_kind_o .. last_of_run_o
//  cfg     | input     | APB psel/penable      | want_rules, want_players
//
// One byte per cycle enters the front end unless in_stall_o is high; its field
// and status items go as one pair through a two-entry queue. The back end sends
// one item per cycle unless out_stall_i is high, so a byte with two items holds
// its entry until both are sent. The output register is loaded from the queue.
// Reset clears all parse state; out_stall_i backs up the queue, then in_stall_o.
`default_nettype none
module query_response_packet_parser import qrpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       field_kind_o,
  output logic [31:0]      field_value_o,
  output logic             string_end_o,
  output logic [15:0]      record_number_o,
  output logic [1:0]       packet_status_o,
  output logic             count_short_o,
  output logic             trailing_bytes_o,
  output logic             query_complete_o,
  output logic             last_of_run_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic  want_rules_q, want_players_q, full, empty, pop, step, wr;
  pair_t pair, qdata;
  item_t item;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_rules_q <= 1'b0; want_players_q <= 1'b0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegWantRules) want_rules_q <= pwdata[0];
      if (paddr[2] == RegWantPlayers) want_players_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegWantRules) prdata[0] = want_rules_q;
      else prdata[0] = want_players_q;
    end
  end

  assign in_stall_o = full;
  assign step = in_valid_i && !full;

  qrpp_front u_front (
    .clk_i, .rst_ni, .step_i(step), .rx_byte_i, .final_byte_i,
    .want_rules_i(want_rules_q), .want_players_i(want_players_q), .pair_o(pair)
  );

  qrpp_queue u_queue (
    .clk_i, .rst_ni, .push_i(step && (pair.v0 || pair.v1)), .data_i(pair),
    .full_o(full), .pop_i(pop), .empty_o(empty), .data_o(qdata)
  );

  qrpp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .data_i(qdata), .pop_o(pop),
    .stall_i(out_stall_i), .valid_o(out_valid_o), .item_o(item)
  );

  assign field_kind_o     = item.kind;
  assign field_value_o    = item.value;
  assign string_end_o     = item.str_end;
  assign record_number_o  = item.rec;
  assign packet_status_o  = item.status;
  assign count_short_o    = item.cnt_short;
  assign trailing_bytes_o = item.trail;
  assign query_complete_o = item.complete;
  assign last_of_run_o    = item.last;
endmodule
`default_nettype wire

// ===== tb/tb_query_response_packet_parser.sv =====
// Self-checking testbench for query_response_packet_parser.
// Depends on qrpp_pkg and the parser RTL; a scoreboard class predicts every field item.
`timescale 1ns / 1ps
`default_nettype none
module tb_query_response_packet_parser;
  import qrpp_pkg::*;

  class parse_scoreboard;
    item_t       expq[$];
    int          fails;
    int          checked;
    int          packets;
    bit          want_rules, want_players;
    logic [15:0] byte_pos, recs_left, rec_idx;
    logic [2:0]  pkt_kind;
    phase_e      phase;
    logic [3:0]  sub_cnt;
    logic [31:0] shift_word, chal_word;
    logic [1:0]  err_latch;
    logic [3:0]  reply_seen;

    function new();
      fails = 0;
      checked = 0;
      packets = 0;
      want_rules = 0;
      want_players = 0;
      chal_word = '0;
      reply_seen = '0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos = '0;
      pkt_kind = '0;
      phase = PH_HDR;
      recs_left = '0;
      rec_idx = '0;
      sub_cnt = '0;
      shift_word = '0;
      err_latch = '0;
    endfunction

    function void push_field(logic [4:0] k, logic [31:0] v, logic se, logic [15:0] r);
      item_t it;
      it = '0;
      it.kind = k;
      it.value = v;
      it.str_end = se;
      it.rec = r;
      expq.push_back(it);
    endfunction

    function void finish_record(phase_e again);
      recs_left = recs_left - 16'd1;
      rec_idx = rec_idx + 16'd1;
      phase = (recs_left != 0) ? again : PH_REC_END;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    // Advance the parse state by one accepted byte and queue the items it causes.
    function void note_input(logic [7:0] b, logic fin);
      int     n0;
      item_t  st_item;
      bit     rec_str;
      logic [15:0] p;
      n0 = expq.size();
      p = byte_pos;
      case (phase)
        PH_HDR: begin
          if (p < 4) begin
            if (b != 8'hFF) begin
              err_latch = ST_BAD_HDR;
              phase = PH_SKIP;
            end
          end else begin
            sub_cnt = '0;
            shift_word = '0;
            if (b == TypeChallenge) begin pkt_kind = 1; phase = PH_CHAL; end
            else if (b == TypeInfo) begin pkt_kind = 2; phase = PH_PROTO; end
            else if (b == TypeRules) begin pkt_kind = 3; phase = PH_RCOUNT; end
            else if (b == TypePlayers) begin pkt_kind = 4; phase = PH_PCOUNT; end
            else begin err_latch = ST_BAD_TYPE; phase = PH_SKIP; end
          end
        end
        PH_CHAL: begin
          shift_word = {b, shift_word[31:8]};
          if (sub_cnt >= 3) begin
            chal_word = shift_word;
            push_field(FK_CHAL, shift_word, 0, 0);
            phase = PH_CHAL_DONE;
          end else sub_cnt++;
        end
        PH_PROTO: begin
          push_field(FK_PROTO, 32'(b), 0, 0);
          phase = PH_S0;
        end
        PH_S0, PH_S1, PH_S2, PH_S3: begin
          push_field(5'(FK_STR0 + (phase - PH_S0)), 32'(b), b == 0, 0);
          if (b == 0) begin
            phase = (phase == PH_S3) ? PH_FIXED : phase_e'(phase + 1);
            sub_cnt = '0;
          end
        end
        PH_FIXED: begin
          case (sub_cnt)
            2: push_field(FK_PLAYERS, 32'(b), 0, 0);
            3: push_field(FK_SLOTS, 32'(b), 0, 0);
            5: push_field(FK_DEDI, 32'(b != 0), 0, 0);
            6: push_field(FK_OS, 32'(b), 0, 0);
            7: if (b != 0) push_field(FK_PASS, 32'(b), 0, 0);
            8: if (b != 0) push_field(FK_SECURE, 32'(b), 0, 0);
            default: ;
          endcase
          if (sub_cnt >= 8) phase = PH_VERSION;
          else sub_cnt++;
        end
        PH_VERSION: begin
          push_field(FK_VERSION, 32'(b), b == 0, 0);
          if (b == 0) phase = PH_INFO_DONE;
        end
        PH_RCOUNT: begin
          if (sub_cnt == 0) begin
            recs_left = {8'd0, b};
            sub_cnt = 1;
          end else begin
            recs_left[15:8] = b;
            sub_cnt = 0;
            phase = (recs_left != 0) ? PH_KEY : PH_REC_END;
          end
        end
        PH_KEY, PH_VALUE: begin
          push_field((phase == PH_KEY) ? FK_KEY : FK_VALUE, 32'(b), b == 0, rec_idx);
          if (b != 0) sub_cnt = 1;
          else begin
            sub_cnt = 0;
            if (phase == PH_KEY) phase = PH_VALUE;
            else finish_record(PH_KEY);
          end
        end
        PH_REC_END, PH_TRAIL: phase = PH_TRAIL;
        PH_PCOUNT: begin
          recs_left = {8'd0, b};
          phase = (recs_left != 0) ? PH_PIDX : PH_REC_END;
        end
        PH_PIDX: begin
          push_field(FK_PIDX, 32'(b), 0, rec_idx);
          sub_cnt = 0;
          phase = PH_PNAME;
        end
        PH_PNAME: begin
          push_field(FK_PNAME, 32'(b), b == 0, rec_idx);
          if (b != 0) sub_cnt = 1;
          else begin
            sub_cnt = 0;
            shift_word = '0;
            phase = PH_FRAGS;
          end
        end
        PH_FRAGS, PH_PTIME: begin
          shift_word = {b, shift_word[31:8]};
          if (sub_cnt >= 3) begin
            push_field((phase == PH_FRAGS) ? FK_FRAGS : FK_TIME, shift_word, 0, rec_idx);
            sub_cnt = 0;
            shift_word = '0;
            if (phase == PH_FRAGS) phase = PH_PTIME;
            else finish_record(PH_PIDX);
          end else sub_cnt++;
        end
        default: ;
      endcase
      if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;

      if (fin) begin
        st_item = '0;
        st_item.kind = FK_STATUS;
        st_item.value = {16'd0, byte_pos};
        st_item.rec = rec_idx;
        st_item.status = ST_SHORT;
        rec_str = (phase == PH_KEY || phase == PH_VALUE || phase == PH_PNAME);
        if (byte_pos < 5) st_item.status = ST_SHORT;
        else if (err_latch != 0) st_item.status = err_latch;
        else if (phase == PH_CHAL_DONE || phase == PH_INFO_DONE || rec_str ||
                 phase == PH_PIDX || phase == PH_REC_END || phase == PH_TRAIL)
          st_item.status = ST_OK;
        if (st_item.status == ST_OK) begin
          st_item.cnt_short = rec_str || phase == PH_PIDX;
          st_item.trail = (phase == PH_TRAIL) || (rec_str && sub_cnt != 0);
          if (phase == PH_CHAL_DONE) reply_seen[0] = 1;
          else if (phase == PH_INFO_DONE) reply_seen[1] = 1;
          else if (pkt_kind == 3) reply_seen[2] = 1;
          else if (pkt_kind == 4) reply_seen[3] = 1;
        end
        st_item.complete = (!want_players || reply_seen[3]) && (!want_rules || reply_seen[2]);
        expq.push_back(st_item);
        packets++;
        clear_packet();
      end
      if (expq.size() > n0) expq[expq.size() - 1].last = 1'b1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      fails++;
      $display("mismatch #%0d at %0t: %s got 0x%0h expected 0x%0h",
               fails, $realtime, what, got, want);
    endtask

    task check_result(item_t got);
      item_t w;
      if (expq.size() == 0) begin
        report("unexpected item, kind", 32'(got.kind), 0);
        return;
      end
      w = expq.pop_front();
      checked++;
      if (got.kind !== w.kind) report("field_kind", 32'(got.kind), 32'(w.kind));
      if (got.value !== w.value) report("field_value", got.value, w.value);
      if (got.str_end !== w.str_end)
        report("string_end", 32'(got.str_end), 32'(w.str_end));
      if (got.rec !== w.rec) report("record_number", 32'(got.rec), 32'(w.rec));
      if (got.status !== w.status)
        report("packet_status", 32'(got.status), 32'(w.status));
      if (got.cnt_short !== w.cnt_short)
        report("count_short", 32'(got.cnt_short), 32'(w.cnt_short));
      if (got.trail !== w.trail) report("trailing_bytes", 32'(got.trail), 32'(w.trail));
      if (got.complete !== w.complete)
        report("query_complete", 32'(got.complete), 32'(w.complete));
      if (got.last !== w.last) report("last_of_run", 32'(got.last), 32'(w.last));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        final_byte_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [4:0]  field_kind_o;
  logic [31:0] field_value_o;
  logic        string_end_o;
  logic [15:0] record_number_o;
  logic [1:0]  packet_status_o;
  logic        count_short_o, trailing_bytes_o, query_complete_o, last_of_run_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  parse_scoreboard sb = new();
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  pkt[$];

  query_response_packet_parser dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: long hold-off when requested, else random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else out_stall_i <= ($urandom_range(99) < snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({field_kind_o, field_value_o, string_end_o, record_number_o,
                       packet_status_o, count_short_o, trailing_bytes_o,
                       query_complete_o, last_of_run_o});
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task drive_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b, fin);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task send_packet();
    foreach (pkt[i]) drive_byte(pkt[i], i == pkt.size() - 1);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task drain();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Write one register and read it back; block must be idle.
  task write_reg(input logic [0:0] idx, input bit val);
    drain();
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= {31'd0, val};
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    if (idx == RegWantRules) sb.want_rules = val;
    else sb.want_players = val;
    pwrite <= 0; penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (prdata[0] !== val) sb.report("register readback", prdata, {31'd0, val});
    @(negedge clk_i);
    psel <= 0; penable <= 0;
  endtask

  task put_str(input int maxlen);
    repeat ($urandom_range(maxlen)) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'h00);
  endtask

  task start_pkt(input logic [7:0] t);
    pkt.delete();
    repeat (4) pkt.push_back(8'hFF);
    pkt.push_back(t);
  endtask

  task build_chal();
    start_pkt(TypeChallenge);
    repeat (4) pkt.push_back(8'($urandom));
  endtask

  task build_info();
    start_pkt(TypeInfo);
    pkt.push_back(8'($urandom));
    repeat (4) put_str(4);
    repeat (9) pkt.push_back(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
    put_str(4);
  endtask

  task build_rules(input int cnt);
    start_pkt(TypeRules);
    pkt.push_back(cnt[7:0]);
    pkt.push_back(cnt[15:8]);
    repeat (cnt) begin
      put_str(3);
      put_str(3);
    end
  endtask

  task build_players(input int cnt);
    start_pkt(TypePlayers);
    pkt.push_back(cnt[7:0]);
    repeat (cnt) begin
      pkt.push_back(8'($urandom));
      put_str(3);
      repeat (8) pkt.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed replies; some cut, padded, corrupted or pure noise.
  task build_random();
    int sel;
    sel = $urandom_range(99);
    case ($urandom_range(3))
      0: build_chal();
      1: build_info();
      2: build_rules($urandom_range(3));
      default: build_players($urandom_range(3));
    endcase
    if (sel < 10) pkt = pkt[0:$urandom_range(pkt.size() - 1)];
    else if (sel < 18) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    else if (sel < 22) pkt[$urandom_range(3)] = 8'($urandom_range(254));
    else if (sel < 26) pkt[4] = 8'($urandom);
    else if (sel < 30) begin
      pkt.delete();
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
    end
  endtask

  task run_phase(input int src, input int snk, input int nbytes, input bit with_hold);
    int start;
    src_idle_pct = src;
    snk_idle_pct = snk;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      if (with_hold && bytes_sent - start > nbytes / 2) begin
        @(posedge clk_i);
        hold_left <= 400;
        @(negedge clk_i);
        with_hold = 0;
      end
      build_random();
      send_packet();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: each reply type, the short, cut, padded and bad cases.
    pkt = '{8'h12};                         send_packet();
    pkt = '{8'h00, 8'h01, 8'h02};            send_packet();
    build_chal();                            send_packet();
    build_chal(); pkt = pkt[0:6];            send_packet();
    build_info(); pkt[14] = 8'h00;           send_packet();
    build_info(); pkt.push_back(8'hFF);      send_packet();
    build_info(); pkt = pkt[0:6];            send_packet();
    build_rules(0);                          send_packet();
    build_rules(2); pkt.push_back(8'hAA);    send_packet();
    build_rules(2); pkt.pop_back();          send_packet();
    build_rules(16'h0102); pkt = pkt[0:24];  send_packet();
    build_rules(1); pkt = pkt[0:6];          send_packet();
    build_players(0);                        send_packet();
    build_players(2);                        send_packet();
    build_players(1); pkt = pkt[0:8];        send_packet();
    build_players(1); pkt.push_back(8'h7F);  send_packet();
    build_players(3); pkt = pkt[0:5];        send_packet();
    start_pkt(8'h00);                        send_packet();
    start_pkt(8'hFF); pkt.push_back(8'h41);  send_packet();
    pkt = '{8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h41, 8'h01, 8'h02, 8'h03, 8'h04};
    send_packet();
    start_pkt(TypeChallenge);                send_packet();

    write_reg(RegWantRules, 1);
    write_reg(RegWantPlayers, 1);
    run_phase(37, 73, 250, 1);
    drain();
    write_reg(RegWantRules, 0);
    run_phase(73, 37, 250, 0);
    drain();
    write_reg(RegWantPlayers, 0);
    write_reg(RegWantRules, 1);
    run_phase(0, 0, 250, 0);
    drain();
    write_reg(RegWantRules, 0);

    begin : wait_end
      int guard;
      guard = 0;
      while (sb.pending() != 0 && guard < 100000) begin
        @(posedge clk_i);
        guard++;
      end
      if (sb.pending() != 0) sb.report("items never delivered", sb.pending(), 0);
    end
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes in %0d datagrams, checked %0d items,", bytes_sent,
             sb.packets, sb.checked);
    $display("covering all reply types, cut and padded replies, bad headers and stalls.");
    if (sb.fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/qrpp_pkg.sv
design/qrpp_front.sv
design/qrpp_queue.sv
design/qrpp_back.sv
design/query_response_packet_parser.sv
tb/tb_query_response_packet_parser.sv
